FILE: rtl/lru_tile_budget_allocator_top_assert.svh
// Assertion macros for the tile budget allocator checkers.
`ifndef LRU_TILE_BUDGET_ALLOCATOR_TOP_ASSERT_SVH
`define LRU_TILE_BUDGET_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LTA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LTA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lta_pkg.sv
// Shared types and constants of the tile budget allocator.
`timescale 1ns / 1ps
package lta_pkg;

  localparam int unsigned TILE_W          = 12;
  localparam int unsigned ID_W            = 4;
  localparam int unsigned ACT_W           = 2;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned POS_W           = 6;
  localparam int unsigned LEN_W           = 7;
  localparam int unsigned SUM_W           = 14;
  localparam int unsigned MAX_CLIENTS_DEF = 16;
  localparam logic [TILE_W-1:0] RESET_LIMIT = 12'd450;

  typedef enum logic [ACT_W-1:0] {
    ACT_REGISTER = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_USE      = 2'd2,
    ACT_REQUEST  = 2'd3
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK   = 2'd0,
    KIND_EVICT = 2'd1,
    KIND_GRANT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_FWD  = 3'd1,
    CELL_REV  = 3'd2,
    CELL_DEL  = 3'd3,
    CELL_MTF  = 3'd4,
    CELL_LOAD = 3'd5,
    CELL_SETT = 3'd6
  } cell_op_e;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_DECODE    = 4'd1,
    ST_FIND      = 4'd2,
    ST_DEL       = 4'd3,
    ST_MTF       = 4'd4,
    ST_DIV_START = 4'd5,
    ST_DIV_WAIT  = 4'd6,
    ST_CHECK     = 4'd7,
    ST_EVICT     = 4'd8,
    ST_GRANT     = 4'd9
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TILE_W-1:0] tiles;
  } cell_t;

  typedef struct packed {
    cell_op_e          op;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [ID_W-1:0]   cid;
    logic [TILE_W-1:0] tiles;
  } cell_ctl_t;

endpackage

FILE: rtl/lta_cell.sv
// One entry of the order list: client id and its tiles, shifted between neighbours.
`timescale 1ns / 1ps
module lta_cell #(
  parameter int unsigned Index = 0
) (
  input  logic              clk_i,
  input  lta_pkg::cell_ctl_t ctl_i,
  input  lta_pkg::cell_t    left_i,
  input  lta_pkg::cell_t    right_i,
  output lta_pkg::cell_t    entry_o
);

  localparam logic [lta_pkg::POS_W-1:0] IdxPos = lta_pkg::POS_W'(Index);
  localparam logic [lta_pkg::LEN_W-1:0] IdxLen = lta_pkg::LEN_W'(Index);

  lta_pkg::cell_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      lta_pkg::CELL_HOLD: ;
      lta_pkg::CELL_FWD:  entry_d = right_i;
      lta_pkg::CELL_REV:  entry_d = left_i;
      lta_pkg::CELL_DEL: begin
        if (IdxPos >= ctl_i.pos) entry_d = right_i;
      end
      lta_pkg::CELL_MTF: begin
        if (Index == 0) begin
          entry_d.id    = ctl_i.cid;
          entry_d.tiles = ctl_i.tiles;
        end else if (IdxPos <= ctl_i.pos) begin
          entry_d = left_i;
        end
      end
      lta_pkg::CELL_LOAD: begin
        if (IdxLen == ctl_i.len) begin
          entry_d.id    = ctl_i.cid;
          entry_d.tiles = '0;
        end
      end
      lta_pkg::CELL_SETT: begin
        if (IdxPos == ctl_i.pos) entry_d.tiles = ctl_i.tiles;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/lta_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lta_div #(
  parameter int unsigned DivW = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lta_pkg::TILE_W-1:0] dividend_i,
  input  logic [DivW-1:0]           divisor_i,
  output logic                      done_o,
  output logic [lta_pkg::TILE_W-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(lta_pkg::TILE_W + 1);

  logic [DivW-1:0]            rem_q, rem_d;
  logic [lta_pkg::TILE_W-1:0] quot_q, quot_d;
  logic [DivW-1:0]            dsr_q, dsr_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [DivW:0]              trial;
  logic                       ge;

  assign trial = {rem_q, quot_q[lta_pkg::TILE_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = CntW'(lta_pkg::TILE_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? DivW'(trial - {1'b0, dsr_q}) : trial[DivW-1:0];
      quot_d = {quot_q[lta_pkg::TILE_W-2:0], ge};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/lru_tile_budget_allocator_top.sv
// Top level of the tile budget allocator with least-recently-used eviction.
`timescale 1ns / 1ps
// Clients are held in a ring of MAX_CLIENTS cells, head first; every search or
// eviction walk rotates the ring once round, one cell per cycle, and leaves it
// aligned again; the eviction walk holds the ring while a notice waits for the
// output. Remove, use and request first rotate once to find the client; a request
// then takes its cap from the serial divider, checks the limit and, if the new
// total exceeds it, rotates backwards for eviction and then grants. Register needs
// no rotation. Each step that writes a result waits while the output is stalled.
// One request is in flight at a time; results leave through a single output
// register that may hold a result while the next step goes on.
module lru_tile_budget_allocator_top #(
  parameter int unsigned MAX_CLIENTS = lta_pkg::MAX_CLIENTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,     // tile_limit
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // action[1:0], client_id[5:2], tile_count[17:6]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // client_id_out[3:0], tiles[15:4], error[16]
  output logic [1:0]  m_axis_tuser_o,  // kind[1:0]
  output logic        m_axis_tlast_o
);

  localparam int unsigned IdxW  = $clog2(MAX_CLIENTS);
  localparam int unsigned LenW  = $clog2(MAX_CLIENTS + 1);
  localparam int unsigned TW    = lta_pkg::TILE_W;
  localparam int unsigned SW    = lta_pkg::SUM_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_CLIENTS - 1);

  lta_pkg::state_e  state_q, state_d;
  lta_pkg::action_e act_q, act_d;
  logic [lta_pkg::ID_W-1:0] cid_q, cid_d;
  logic [TW-1:0]    want_q, want_d;
  logic [TW-1:0]    limit_q, limit_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [MAX_CLIENTS-1:0] present_q, present_d;
  logic [TW-1:0]    total_q, total_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  logic [TW-1:0]    old_q, old_d;
  logic             found_q, found_d;
  logic [TW-1:0]    ask_q, ask_d;
  logic [SW-1:0]    newtot_q, newtot_d;
  logic [SW-1:0]    need_q, need_d;
  logic [SW-1:0]    evicted_q, evicted_d;
  logic             stop_q, stop_d;

  logic             out_valid_q, out_valid_d;
  lta_pkg::kind_e   out_kind_q, out_kind_d;
  logic [lta_pkg::ID_W-1:0] out_id_q, out_id_d;
  logic [TW-1:0]    out_tiles_q, out_tiles_d;
  logic             out_err_q, out_err_d;
  logic             out_last_q, out_last_d;

  lta_pkg::cell_ctl_t ctl;
  lta_pkg::cell_t     cells_w [MAX_CLIENTS];
  lta_pkg::cell_t     wrap_w;
  logic               clr_wrap;

  logic            in_hs, out_free;
  logic            id_valid, present;
  logic [IdxW-1:0] pidx;
  logic            find_last;
  logic            div_start, div_done;
  logic [TW-1:0]   quot;
  logic [TW-1:0]   ask_w;
  logic [IdxW-1:0] ev_idx;
  logic            ev_act;
  logic [SW-1:0]   ev_sum;
  logic            enough;
  logic [SW-1:0]   others;
  logic [TW-1:0]   grant;

  assign in_hs     = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign id_valid  = 32'(cid_q) < MAX_CLIENTS;
  assign pidx      = IdxW'(cid_q);
  assign present   = id_valid && present_q[pidx];
  assign find_last = cnt_q == LastIdx;
  assign ask_w     = (want_q < quot) ? want_q : quot;
  assign ev_idx    = LastIdx - cnt_q;
  assign ev_act    = !stop_q && (LenW'(ev_idx) < len_q) && (ev_idx > pos_q);
  assign ev_sum    = evicted_q + SW'(cells_w[MAX_CLIENTS-1].tiles);
  assign enough    = evicted_q >= need_q;
  assign others    = SW'(total_q) - SW'(old_q) - evicted_q;

  always_comb begin
    if (enough) begin
      grant = ask_q;
    end else if (SW'(limit_q) > others) begin
      grant = TW'(SW'(limit_q) - others);
    end else begin
      grant = '0;
    end
  end

  // Ring of cells; the wrap path clears the tiles of an evicted client.
  assign wrap_w.id    = cells_w[MAX_CLIENTS-1].id;
  assign wrap_w.tiles = clr_wrap ? '0 : cells_w[MAX_CLIENTS-1].tiles;

  for (genvar g = 0; g < MAX_CLIENTS; g++) begin : g_cell
    lta_pkg::cell_t left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = wrap_w;
    end else begin : g_body
      assign left_w = cells_w[g-1];
    end
    if (g == MAX_CLIENTS - 1) begin : g_tail
      assign right_w = cells_w[0];
    end else begin : g_mid
      assign right_w = cells_w[g+1];
    end
    lta_cell #(
      .Index(g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .left_i (left_w),
      .right_i(right_w),
      .entry_o(cells_w[g])
    );
  end

  lta_div #(
    .DivW(LenW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(limit_q),
    .divisor_i (LenW'(pos_q) + LenW'(1)),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lta_pkg::ST_IDLE: begin
        if (in_hs) state_d = lta_pkg::ST_DECODE;
      end
      lta_pkg::ST_DECODE: begin
        if (act_q == lta_pkg::ACT_REGISTER || !present) begin
          if (out_free) state_d = lta_pkg::ST_IDLE;
        end else begin
          state_d = lta_pkg::ST_FIND;
        end
      end
      lta_pkg::ST_FIND: begin
        if (find_last) begin
          priority case (act_q)
            lta_pkg::ACT_REMOVE: state_d = lta_pkg::ST_DEL;
            lta_pkg::ACT_USE:    state_d = lta_pkg::ST_MTF;
            default:             state_d = lta_pkg::ST_DIV_START;
          endcase
        end
      end
      lta_pkg::ST_DEL, lta_pkg::ST_MTF: begin
        if (out_free) state_d = lta_pkg::ST_IDLE;
      end
      lta_pkg::ST_DIV_START: state_d = lta_pkg::ST_DIV_WAIT;
      lta_pkg::ST_DIV_WAIT: begin
        if (div_done) state_d = lta_pkg::ST_CHECK;
      end
      lta_pkg::ST_CHECK: begin
        if (newtot_q > SW'(limit_q)) begin
          state_d = lta_pkg::ST_EVICT;
        end else if (out_free) begin
          state_d = lta_pkg::ST_IDLE;
        end
      end
      lta_pkg::ST_EVICT: begin
        if (!(ev_act && !out_free) && find_last) state_d = lta_pkg::ST_GRANT;
      end
      lta_pkg::ST_GRANT: begin
        if (out_free) state_d = lta_pkg::ST_IDLE;
      end
      default: state_d = lta_pkg::ST_IDLE;
    endcase
  end

  // Datapath, cell control and result register.
  always_comb begin
    act_d     = act_q;
    cid_d     = cid_q;
    want_d    = want_q;
    limit_d   = cfg_we_i ? cfg_wdata_i : limit_q;
    len_d     = len_q;
    present_d = present_q;
    total_d   = total_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    old_d     = old_q;
    found_d   = found_q;
    ask_d     = ask_q;
    newtot_d  = newtot_q;
    need_d    = need_q;
    evicted_d = evicted_q;
    stop_d    = stop_q;
    div_start = 1'b0;
    clr_wrap  = 1'b0;

    ctl.op    = lta_pkg::CELL_HOLD;
    ctl.pos   = lta_pkg::POS_W'(pos_q);
    ctl.len   = lta_pkg::LEN_W'(len_q);
    ctl.cid   = cid_q;
    ctl.tiles = old_q;

    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_tiles_d = out_tiles_q;
    out_err_d   = out_err_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      lta_pkg::ST_IDLE: begin
        if (in_hs) begin
          act_d  = lta_pkg::action_e'(s_axis_tdata_i[1:0]);
          cid_d  = s_axis_tdata_i[5:2];
          want_d = s_axis_tdata_i[17:6];
        end
      end
      lta_pkg::ST_DECODE: begin
        cnt_d   = '0;
        found_d = 1'b0;
        if (act_q == lta_pkg::ACT_REGISTER || !present) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_kind_d  = (act_q == lta_pkg::ACT_REQUEST) ? lta_pkg::KIND_GRANT
                                                          : lta_pkg::KIND_ACK;
            out_id_d    = cid_q;
            out_tiles_d = '0;
            out_last_d  = 1'b1;
            if (act_q == lta_pkg::ACT_REGISTER) begin
              out_err_d = !id_valid || present || (32'(len_q) >= MAX_CLIENTS);
              if (!(!id_valid || present || (32'(len_q) >= MAX_CLIENTS))) begin
                ctl.op          = lta_pkg::CELL_LOAD;
                present_d[pidx] = 1'b1;
                len_d           = len_q + LenW'(1);
              end
            end else begin
              out_err_d = 1'b1;
            end
          end
        end
      end
      lta_pkg::ST_FIND: begin
        // The head cell shows list entry cnt in this cycle.
        ctl.op = lta_pkg::CELL_FWD;
        cnt_d  = cnt_q + IdxW'(1);
        if (!found_q && (LenW'(cnt_q) < len_q) && (cells_w[0].id == cid_q)) begin
          found_d = 1'b1;
          pos_d   = cnt_q;
          old_d   = cells_w[0].tiles;
        end
      end
      lta_pkg::ST_DEL: begin
        if (out_free) begin
          ctl.op          = lta_pkg::CELL_DEL;
          total_d         = total_q - old_q;
          present_d[pidx] = 1'b0;
          len_d           = len_q - LenW'(1);
          out_valid_d     = 1'b1;
          out_kind_d      = lta_pkg::KIND_ACK;
          out_id_d        = cid_q;
          out_tiles_d     = '0;
          out_err_d       = 1'b0;
          out_last_d      = 1'b1;
        end
      end
      lta_pkg::ST_MTF: begin
        if (out_free) begin
          ctl.op      = lta_pkg::CELL_MTF;
          out_valid_d = 1'b1;
          out_kind_d  = lta_pkg::KIND_ACK;
          out_id_d    = cid_q;
          out_tiles_d = '0;
          out_err_d   = 1'b0;
          out_last_d  = 1'b1;
        end
      end
      lta_pkg::ST_DIV_START: div_start = 1'b1;
      lta_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          ask_d    = ask_w;
          newtot_d = SW'(total_q) - SW'(old_q) + SW'(ask_w);
        end
      end
      lta_pkg::ST_CHECK: begin
        cnt_d     = '0;
        stop_d    = 1'b0;
        evicted_d = '0;
        need_d    = newtot_q - SW'(limit_q);
        if (newtot_q <= SW'(limit_q) && out_free) begin
          ctl.op      = lta_pkg::CELL_SETT;
          ctl.tiles   = ask_q;
          total_d     = TW'(newtot_q);
          out_valid_d = 1'b1;
          out_kind_d  = lta_pkg::KIND_GRANT;
          out_id_d    = cid_q;
          out_tiles_d = ask_q;
          out_err_d   = 1'b0;
          out_last_d  = 1'b1;
        end
      end
      lta_pkg::ST_EVICT: begin
        // The tail cell shows list entry ev_idx; hold the ring while a notice waits.
        if (!(ev_act && !out_free)) begin
          ctl.op   = lta_pkg::CELL_REV;
          clr_wrap = ev_act;
          cnt_d    = cnt_q + IdxW'(1);
          if (ev_act) begin
            evicted_d   = ev_sum;
            stop_d      = ev_sum >= need_q;
            out_valid_d = 1'b1;
            out_kind_d  = lta_pkg::KIND_EVICT;
            out_id_d    = cells_w[MAX_CLIENTS-1].id;
            out_tiles_d = cells_w[MAX_CLIENTS-1].tiles;
            out_err_d   = 1'b0;
            out_last_d  = 1'b0;
          end
        end
      end
      lta_pkg::ST_GRANT: begin
        if (out_free) begin
          ctl.op      = lta_pkg::CELL_SETT;
          ctl.tiles   = grant;
          total_d     = enough ? TW'(newtot_q - evicted_q) : TW'(others + SW'(grant));
          out_valid_d = 1'b1;
          out_kind_d  = lta_pkg::KIND_GRANT;
          out_id_d    = cid_q;
          out_tiles_d = grant;
          out_err_d   = 1'b0;
          out_last_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lta_pkg::ST_IDLE;
      limit_q     <= lta_pkg::RESET_LIMIT;
      len_q       <= '0;
      present_q   <= '0;
      total_q     <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      len_q       <= len_d;
      present_q   <= present_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    cid_q       <= cid_d;
    want_q      <= want_d;
    pos_q       <= pos_d;
    old_q       <= old_d;
    ask_q       <= ask_d;
    newtot_q    <= newtot_d;
    need_q      <= need_d;
    evicted_q   <= evicted_d;
    out_kind_q  <= out_kind_d;
    out_id_q    <= out_id_d;
    out_tiles_q <= out_tiles_d;
    out_err_q   <= out_err_d;
    out_last_q  <= out_last_d;
  end

  assign s_axis_tready_o = state_q == lta_pkg::ST_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_err_q, out_tiles_q, out_id_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

FILE: rtl/lta_checker.sv
// Port-level checks of the tile budget allocator, bound to the top level.
`timescale 1ns / 1ps
`include "lru_tile_budget_allocator_top_assert.svh"
module lta_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // Hold a stalled result.
  `LTA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "stalled result changed")
  // One request at a time: drop ready after taking one.
  `LTA_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "ready stayed high after a request")
  `LTA_ASSERT_IMP(a_kind_code, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tuser_o == lta_pkg::KIND_ACK || m_axis_tuser_o == lta_pkg::KIND_EVICT || m_axis_tuser_o == lta_pkg::KIND_GRANT, "unknown result kind")
  `LTA_ASSERT_IMP(a_ack_form, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o == lta_pkg::KIND_ACK, m_axis_tlast_o && m_axis_tdata_o[15:4] == 12'd0, "acknowledge not final or carries tiles")
  `LTA_ASSERT_IMP(a_notice_form, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o == lta_pkg::KIND_EVICT, !m_axis_tlast_o && !m_axis_tdata_o[16], "eviction notice marked final or in error")

endmodule

bind lru_tile_budget_allocator_top lta_checker u_lta_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

FILE: tb/lru_tile_budget_allocator_top_tb.sv
// Self-checking testbench for the tile budget allocator with least-recently-used eviction.
`timescale 1ns / 1ps
module lru_tile_budget_allocator_top_tb;

  typedef struct packed {
    lta_pkg::kind_e kind;
    logic [3:0]  cid;
    logic [11:0] tiles;
    logic        err;
    logic        last;
  } alloc_res_t;

  typedef struct {
    lta_pkg::action_e act;
    logic [3:0]  cid;
    logic [11:0] count;
    logic        has_exp;
    alloc_res_t  exp;
  } req_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [11:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  lru_tile_budget_allocator_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i), .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i), .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tuser_o(m_axis_tuser_o), .m_axis_tlast_o(m_axis_tlast_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state
  logic [11:0] limit_q;
  logic [3:0]  mru_order [16];
  int          order_len;
  logic [11:0] held_tiles [16];
  logic        is_member [16];
  logic [11:0] sum_tiles;

  alloc_res_t  pending_res [$];
  int          fail_cnt = 0;
  bit          hold_off = 1'b0;
  bit          rx_quiet = 1'b0;

  function automatic alloc_res_t mk(lta_pkg::kind_e k, logic [3:0] c, logic [11:0] t,
                                    logic e, logic l);
    alloc_res_t r;
    r.kind = k; r.cid = c; r.tiles = t; r.err = e; r.last = l;
    return r;
  endfunction

  function automatic void queue_res(alloc_res_t r);
    pending_res.insert(pending_res.size(), r);
  endfunction

  function automatic int pos_of(logic [3:0] c);
    for (int i = 0; i < order_len; i++)
      if (mru_order[i] == c) return i;
    return order_len;
  endfunction

  task automatic predict_alloc(lta_pkg::action_e act, logic [3:0] c, logic [11:0] want);
    int p;
    longint cap, ask, old, ntot, need, freed, others, grant;
    int n;
    logic [3:0] v;
    p = 0; n = 0;
    if (act == lta_pkg::ACT_REGISTER) begin
      if (is_member[c] || order_len >= 16) begin
        queue_res(mk(lta_pkg::KIND_ACK, c, 12'd0, 1'b1, 1'b1));
      end else begin
        mru_order[order_len] = c; order_len++;
        is_member[c] = 1'b1; held_tiles[c] = '0;
        queue_res(mk(lta_pkg::KIND_ACK, c, 12'd0, 1'b0, 1'b1));
      end
      return;
    end
    if (act != lta_pkg::ACT_REQUEST) begin
      if (!is_member[c]) begin
        queue_res(mk(lta_pkg::KIND_ACK, c, 12'd0, 1'b1, 1'b1));
        return;
      end
      p = pos_of(c);
      if (act == lta_pkg::ACT_REMOVE) begin
        sum_tiles = sum_tiles - held_tiles[c];
        held_tiles[c] = '0; is_member[c] = 1'b0;
        for (int i = p; i + 1 < order_len; i++) mru_order[i] = mru_order[i+1];
        order_len--;
      end else begin
        for (int i = p; i > 0; i--) mru_order[i] = mru_order[i-1];
        mru_order[0] = c;
      end
      queue_res(mk(lta_pkg::KIND_ACK, c, 12'd0, 1'b0, 1'b1));
      return;
    end
    if (!is_member[c]) begin
      queue_res(mk(lta_pkg::KIND_GRANT, c, 12'd0, 1'b1, 1'b1));
      return;
    end
    p = pos_of(c);
    cap = limit_q / (p + 1);
    ask = (want < cap) ? want : cap;
    old = held_tiles[c];
    ntot = sum_tiles - old + ask;
    if (ntot <= limit_q) begin
      sum_tiles = 12'(ntot); held_tiles[c] = 12'(ask);
      queue_res(mk(lta_pkg::KIND_GRANT, c, 12'(ask), 1'b0, 1'b1));
      return;
    end
    need = ntot - limit_q;
    freed = 0;
    for (int k = order_len; k > 0 && n < 15; k--) begin
      v = mru_order[k-1];
      if (v == c) break;
      freed += held_tiles[v];
      queue_res(mk(lta_pkg::KIND_EVICT, v, held_tiles[v], 1'b0, 1'b0));
      held_tiles[v] = '0;
      n++;
      if (freed >= need) break;
    end
    if (freed >= need) begin
      sum_tiles = 12'(ntot - freed); grant = ask;
    end else begin
      others = sum_tiles - old - freed;
      grant = (limit_q > others) ? limit_q - others : 0;
      sum_tiles = 12'(others + grant);
    end
    held_tiles[c] = 12'(grant);
    queue_res(mk(lta_pkg::KIND_GRANT, c, 12'(grant), 1'b0, 1'b1));
  endtask

  // Result checker: compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin
    alloc_res_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = mk(lta_pkg::kind_e'(m_axis_tuser_o), m_axis_tdata_o[3:0], m_axis_tdata_o[15:4],
               m_axis_tdata_o[16], m_axis_tlast_o);
      if (pending_res.size() == 0) begin
        $display("%0t: exp no result got %p", $time, got);
        fail_cnt++;
      end else begin
        want = pending_res.pop_front();
        if (got.kind !== want.kind)
          $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
        if (got.cid !== want.cid)
          $display("%0t: client exp %0d got %0d", $time, want.cid, got.cid);
        if (got.tiles !== want.tiles)
          $display("%0t: tiles exp %0d got %0d", $time, want.tiles, got.tiles);
        if (got.err !== want.err)
          $display("%0t: error exp %0b got %0b", $time, want.err, got.err);
        if (got.last !== want.last)
          $display("%0t: last exp %0b got %0b", $time, want.last, got.last);
        if (got !== want) fail_cnt++;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request
  initial begin
    int ph;
    ph = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      ph++;
      if (rx_quiet) m_axis_tready_i <= 1'b1;
      else if ((ph % 37) < 12) m_axis_tready_i <= 1'b1;
      else m_axis_tready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_req(lta_pkg::action_e act, logic [3:0] c, logic [11:0] cnt);
    @(negedge clk_i);
    s_axis_tdata_i  <= {6'd0, cnt, c, act};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_alloc(act, c, cnt);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  // Sender offers back-to-back within a burst: valid stays high across items
  task automatic send_burst(int len, bit shaped);
    lta_pkg::action_e a; logic [3:0] c; logic [11:0] t;
    @(negedge clk_i);
    for (int i = 0; i < len; i++) begin
      if (shaped) begin
        case ($urandom_range(0, 9))
          0, 1:    a = lta_pkg::ACT_REGISTER;
          2:       a = lta_pkg::ACT_REMOVE;
          3, 4:    a = lta_pkg::ACT_USE;
          default: a = lta_pkg::ACT_REQUEST;
        endcase
        c = (order_len > 0 && $urandom_range(0, 3) != 0) ?
            mru_order[$urandom_range(0, order_len - 1)] : 4'($urandom);
        t = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 200));
      end else begin
        a = lta_pkg::action_e'(2'($urandom)); c = 4'($urandom); t = 12'($urandom);
      end
      s_axis_tdata_i  <= {6'd0, t, c, a};
      s_axis_tvalid_i <= 1'b1;
      do @(posedge clk_i); while (!s_axis_tready_o);
      predict_alloc(a, c, t);
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [11:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limit_q = v;
  endtask

  req_row_t script [$];

  function automatic req_row_t row(lta_pkg::action_e a, logic [3:0] c, logic [11:0] t,
                                   logic h, alloc_res_t e);
    req_row_t r;
    r.act = a; r.cid = c; r.count = t; r.has_exp = h; r.exp = e;
    return r;
  endfunction

  function automatic void add_row(req_row_t r);
    script.insert(script.size(), r);
  endfunction

  initial begin
    alloc_res_t nil;
    logic [11:0] limits [5];
    nil = '0;
    limit_q = lta_pkg::RESET_LIMIT; order_len = 0; sum_tiles = '0;
    for (int i = 0; i < 16; i++) begin
      held_tiles[i] = '0; is_member[i] = 1'b0; mru_order[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, under the reset limit
    add_row(row(lta_pkg::ACT_REMOVE, 4'd3, 12'd0, 1'b1,
                mk(lta_pkg::KIND_ACK, 4'd3, 12'd0, 1'b1, 1'b1)));
    add_row(row(lta_pkg::ACT_USE, 4'd15, 12'd0, 1'b1,
                mk(lta_pkg::KIND_ACK, 4'd15, 12'd0, 1'b1, 1'b1)));
    add_row(row(lta_pkg::ACT_REQUEST, 4'd0, 12'd4095, 1'b1,
                mk(lta_pkg::KIND_GRANT, 4'd0, 12'd0, 1'b1, 1'b1)));
    add_row(row(lta_pkg::ACT_REGISTER, 4'd0, 12'd0, 1'b1,
                mk(lta_pkg::KIND_ACK, 4'd0, 12'd0, 1'b0, 1'b1)));
    add_row(row(lta_pkg::ACT_REGISTER, 4'd0, 12'd0, 1'b1,
                mk(lta_pkg::KIND_ACK, 4'd0, 12'd0, 1'b1, 1'b1)));
    add_row(row(lta_pkg::ACT_REQUEST, 4'd0, 12'd4095, 1'b1,
                mk(lta_pkg::KIND_GRANT, 4'd0, 12'd450, 1'b0, 1'b1)));
    add_row(row(lta_pkg::ACT_REGISTER, 4'd15, 12'd0, 1'b1,
                mk(lta_pkg::KIND_ACK, 4'd15, 12'd0, 1'b0, 1'b1)));
    add_row(row(lta_pkg::ACT_REGISTER, 4'd7, 12'd0, 1'b0, nil));
    add_row(row(lta_pkg::ACT_REGISTER, 4'd9, 12'd0, 1'b0, nil));
    add_row(row(lta_pkg::ACT_REQUEST, 4'd15, 12'd0, 1'b0, nil));
    add_row(row(lta_pkg::ACT_USE, 4'd9, 12'd0, 1'b0, nil));
    add_row(row(lta_pkg::ACT_REQUEST, 4'd9, 12'd300, 1'b0, nil));
    add_row(row(lta_pkg::ACT_REQUEST, 4'd7, 12'd100, 1'b0, nil));
    add_row(row(lta_pkg::ACT_REQUEST, 4'd0, 12'd2730, 1'b0, nil));
    add_row(row(lta_pkg::ACT_REMOVE, 4'd7, 12'd0, 1'b0, nil));
    add_row(row(lta_pkg::ACT_REQUEST, 4'd15, 12'd4095, 1'b0, nil));
    add_row(row(lta_pkg::ACT_USE, 4'd15, 12'd0, 1'b0, nil));
    add_row(row(lta_pkg::ACT_REQUEST, 4'd9, 12'd1365, 1'b0, nil));
    foreach (script[i]) begin
      send_req(script[i].act, script[i].cid, script[i].count);
      if (script[i].has_exp && pending_res[$] !== script[i].exp) begin
        $display("%0t: row %0d exp %p predicted %p", $time, i, script[i].exp,
                 pending_res[$]);
        fail_cnt++;
      end
    end
    // Limit lowered below the allocated total: eviction falls short
    drain_all();
    set_limit(12'd20);
    send_req(lta_pkg::ACT_REQUEST, 4'd0, 12'd10);
    send_req(lta_pkg::ACT_REQUEST, 4'd0, 12'd4095);

    // Random part across several limits, extremes included
    limits[0] = 12'd0; limits[1] = 12'd4095; limits[2] = 12'd450;
    limits[3] = 12'd1; limits[4] = 12'd700;
    for (int ph = 0; ph < 5; ph++) begin
      drain_all();
      set_limit(ph == 4 ? 12'($urandom) : limits[ph]);
      for (int b = 0; b < 16; b++) begin
        if (ph == 1 && b == 4) hold_off = 1'b1;
        if (b == 8) begin
          // pause until every result is in
          rx_quiet = (ph == 2);
          while (pending_res.size() != 0) @(posedge clk_i);
          rx_quiet = 1'b0;
        end
        send_burst($urandom_range(1, 8), $urandom_range(0, 7) != 0);
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end
    end
    drain_all();
    if (fail_cnt == 0 && pending_res.size() == 0) begin
      $display("lru_tile_budget_allocator_top: match");
    end else begin
      $display("lru_tile_budget_allocator_top: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("lru_tile_budget_allocator_top: mismatch");
    $finish;
  end

endmodule
